// ===== rtl/pnh_pkg.sv =====
// Package for the position noise hash: constants, mode codes and pipeline types.
// No dependencies; used by every module in rtl.
`timescale 1ns / 1ps
package pnh_pkg;
    localparam logic [31:0] MUL_A   = 32'hB5297A4D;
    localparam logic [31:0] ADD_B   = 32'h68E31DA4;
    localparam logic [31:0] MUL_C   = 32'h1B56C4E9;
    localparam logic [31:0] PRIME_Y = 32'd198491317;
    localparam logic [31:0] PRIME_Z = 32'd6542989;
    localparam int          DIV_BITS = 32;
    localparam int          SEED_RESET = 0;

    typedef enum logic [2:0] {
        FN_HASH1D = 3'd0,
        FN_HASH2D = 3'd1,
        FN_HASH3D = 3'd2,
        FN_RAND   = 3'd3,
        FN_RANGE  = 3'd4
    } func_t;

    // Side data that travels with a word through the divider.
    typedef struct packed {
        logic [31:0] hash;
        logic [31:0] low;
        logic        is_range;
        logic        err;
    } side_t;
endpackage

// ===== rtl/position_noise_hash.sv =====
// Position noise hash: five hash stages feed a 33-stage remainder pipeline and an
// output register. Throughput is one word per cycle while the output word is not
// stalled, set by the fully pipelined multiplies and one remainder bit per stage.
// The whole pipeline advances together and freezes while the output word is stalled.
// Reset (rst_n, asynchronous) clears all valid bits and sets the seed to zero.
`timescale 1ns / 1ps
module position_noise_hash (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        seed_we,
    input  logic [31:0] seed_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  func,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    input  logic signed [31:0] low_bound,
    input  logic signed [31:0] high_bound,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] hash,
    output logic signed [31:0] range_value,
    output logic        range_error
);
    import pnh_pkg::*;

    logic [31:0] seed_val_reg;
    logic        en;
    logic        h_valid, h_is_range;
    logic [31:0] h_hash, h_range, h_low;
    side_t       h_side, m_side;
    logic        m_valid;
    logic [DIV_BITS-1:0] m_rem;
    logic        o_valid_reg;
    logic [31:0] o_hash_reg, o_range_reg;
    logic        o_err_reg;

    // The seed register is written whenever the enable is high.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_val_reg <= 32'(SEED_RESET);
        end
        else if (seed_we)
        begin
            seed_val_reg <= seed_wdata;
        end
    end

    // The pipeline moves when the output register is empty or being drained.
    assign en       = ~o_valid_reg | out_ready;
    assign in_ready = en;

    pnh_hash_pipe u_hash (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(in_valid & en),
        .func(func), .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
        .low_bound(low_bound), .high_bound(high_bound), .seed(seed_val_reg),
        .out_valid(h_valid), .out_hash(h_hash), .out_range(h_range),
        .out_low(h_low), .out_is_range(h_is_range)
    );

    // A zero range becomes a divide by one; the error bit masks the result.
    always_comb
    begin
        h_side.hash     = h_hash;
        h_side.low      = h_low;
        h_side.is_range = h_is_range;
        h_side.err      = (h_range == 32'd0);
    end

    pnh_mod_pipe #(.N(DIV_BITS)) u_mod (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(h_valid),
        .dividend(h_hash), .divisor((h_range == 32'd0) ? 32'd1 : h_range),
        .in_side(h_side), .out_valid(m_valid), .remainder(m_rem), .out_side(m_side)
    );

    // Output register: loads the finished word whenever the pipeline advances.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            o_valid_reg <= m_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            o_hash_reg  <= m_side.hash;
            o_err_reg   <= m_side.is_range & m_side.err;
            o_range_reg <= (m_side.is_range && !m_side.err) ? (m_rem + m_side.low) : 32'd0;
        end
    end

    assign out_valid   = o_valid_reg;
    assign hash        = o_hash_reg;
    assign range_value = o_range_reg;
    assign range_error = o_err_reg;

    // A stalled output word must hold its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(hash))
        else $error("output word changed while stalled");
    // An error word never carries a range value.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && range_error |-> range_value == 32'd0)
        else $error("range error with nonzero value");
    // Input is taken exactly when the pipeline advances.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("ready does not follow pipeline enable");
endmodule

// ===== rtl/pnh_hash_pipe.sv =====
// Pipelined squirrel hash with position folding; one word per cycle while en is high.
// Depends on pnh_pkg.
`timescale 1ns / 1ps
module pnh_hash_pipe (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  logic [2:0]         func,
    input  logic [31:0]        pos_x,
    input  logic [31:0]        pos_y,
    input  logic [31:0]        pos_z,
    input  logic [31:0]        low_bound,
    input  logic [31:0]        high_bound,
    input  logic [31:0]        seed,
    output logic               out_valid,
    output logic [31:0]        out_hash,
    output logic [31:0]        out_range,
    output logic [31:0]        out_low,
    output logic               out_is_range
);
    import pnh_pkg::*;

    // Stage regs: s1 products, s2 fold, s3 first mul, s4 mix, s5 second mul.
    logic [4:0]  v_reg;
    logic [2:0]  f_reg [1:5];
    logic [31:0] lo_reg [1:5];
    logic [31:0] r_reg [1:5];
    logic [31:0] px1_reg, py1_reg, pz1_reg;
    logic [31:0] p2_reg, m3_reg, m4_reg, m5_reg;
    logic [31:0] m3s, a4, m4x;

    assign m3s = m3_reg + seed;
    assign a4  = (m3s ^ (m3s >> 8)) + ADD_B;
    assign m4x = a4 ^ (a4 << 8);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[3:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f_reg[1]  <= func;
            lo_reg[1] <= low_bound;
            r_reg[1]  <= high_bound - low_bound + 32'd1;
            for (int i = 2; i <= 5; i++)
            begin
                f_reg[i]  <= f_reg[i-1];
                lo_reg[i] <= lo_reg[i-1];
                r_reg[i]  <= r_reg[i-1];
            end
            px1_reg <= pos_x;
            py1_reg <= PRIME_Y * pos_y;
            pz1_reg <= PRIME_Z * pos_z;
            unique case (f_reg[1])
                FN_HASH2D: p2_reg <= px1_reg + py1_reg;
                FN_HASH3D: p2_reg <= px1_reg + py1_reg + pz1_reg;
                FN_RAND:   p2_reg <= PRIME_Y;
                default:   p2_reg <= px1_reg;
            endcase
            m3_reg <= p2_reg * MUL_A;
            m4_reg <= m4x;
            m5_reg <= m4_reg * MUL_C;
        end
    end

    assign out_valid    = v_reg[4];
    assign out_hash     = (f_reg[5] <= FN_RANGE) ? (m5_reg ^ (m5_reg >> 8)) : 32'd0;
    assign out_range    = r_reg[5];
    assign out_low      = lo_reg[5];
    assign out_is_range = (f_reg[5] == FN_RANGE);
endmodule

// ===== rtl/pnh_mod_pipe.sv =====
// Pipelined restoring unsigned remainder, one quotient bit per stage.
// Depends on pnh_pkg.
`timescale 1ns / 1ps
module pnh_mod_pipe #(
    parameter int N = pnh_pkg::DIV_BITS
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_valid,
    input  logic [N-1:0]   dividend,
    input  logic [N-1:0]   divisor,
    input  pnh_pkg::side_t in_side,
    output logic           out_valid,
    output logic [N-1:0]   remainder,
    output pnh_pkg::side_t out_side
);
    import pnh_pkg::*;

    logic [N:0]   v_reg;
    logic [N-1:0] q_reg [0:N];
    logic [N-1:0] rem_reg [0:N];
    logic [N-1:0] d_reg [0:N];
    side_t        s_reg [0:N];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[N-1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg[0]   <= dividend;
            rem_reg[0] <= '0;
            d_reg[0]   <= divisor;
            s_reg[0]   <= in_side;
            for (int i = 0; i < N; i++)
            begin
                logic [N:0] t;
                t = {rem_reg[i], q_reg[i][N-1]};
                if (t >= {1'b0, d_reg[i]})
                begin
                    t = t - {1'b0, d_reg[i]};
                end
                rem_reg[i+1] <= t[N-1:0];
                q_reg[i+1]   <= {q_reg[i][N-2:0], 1'b0};
                d_reg[i+1]   <= d_reg[i];
                s_reg[i+1]   <= s_reg[i];
            end
        end
    end

    assign out_valid = v_reg[N];
    assign remainder = rem_reg[N];
    assign out_side  = s_reg[N];
endmodule
